// ===== hw/rtl/three_by_three_linear_solver_defines.svh =====
// Assertion macros for the three-plane solver.
`ifndef THREE_BY_THREE_LINEAR_SOLVER_DEFINES_SVH
`define THREE_BY_THREE_LINEAR_SOLVER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define LSOLVE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an expression never holds outside reset.
`define LSOLVE_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/lsolve_pkg.sv =====
// Types and constants shared by the three-plane solver modules.
package lsolve_pkg;

	localparam int COEF_W    = 16;
	localparam int NCOEF     = 12;
	localparam int PROD_W    = 32;
	localparam int MINOR_W   = 33;
	localparam int TERM_W    = 49;
	localparam int DET_W     = 50;
	localparam int MAG_W     = 48;
	localparam int FRAC_W    = 16;
	localparam int Q_W       = 33;
	localparam int SOL_W     = 32;
	localparam int DET_LAT   = 4;
	localparam int DIV_STEPS = Q_W;
	localparam int DIV_LAT   = DIV_STEPS + 2;
	localparam int TOT_LAT   = DET_LAT + 1 + DIV_LAT;

	// Column indexes inside one plane row.
	localparam int COL_A = 0;
	localparam int COL_B = 1;
	localparam int COL_C = 2;
	localparam int COL_D = 3;

	// Minors of rows two and three, by column pair.
	localparam int NPAIR = 6;
	localparam int M_AB = 0;
	localparam int M_AC = 1;
	localparam int M_AD = 2;
	localparam int M_BC = 3;
	localparam int M_BD = 4;
	localparam int M_CD = 5;
	localparam int PAIR_I [NPAIR] = '{COL_A, COL_A, COL_A, COL_B, COL_B, COL_C};
	localparam int PAIR_J [NPAIR] = '{COL_B, COL_C, COL_D, COL_C, COL_D, COL_D};

	typedef enum logic [1:0] {
		ST_SOLVED    = 2'd0,
		ST_SINGULAR  = 2'd1,
		ST_SATURATED = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [DET_W-1:0] den;
		logic signed [DET_W-1:0] nx;
		logic signed [DET_W-1:0] ny;
		logic signed [DET_W-1:0] nz;
	} det_t;

	localparam logic [SOL_W-1:0] SAT_POS = {1'b0, {(SOL_W-1){1'b1}}};
	localparam logic [SOL_W-1:0] SAT_NEG = {1'b1, {(SOL_W-1){1'b0}}};

endpackage

// ===== hw/rtl/lsolve_det.sv =====
// Four-stage pipeline forming the system determinant and the three Cramer numerators.
module lsolve_det
	import lsolve_pkg::*;
(
	input  logic                      clk,
	input  logic                      en,
	input  logic [NCOEF*COEF_W-1:0]   coef,
	output det_t                      det
);

	logic signed [COEF_W-1:0]  row1_s1 [4];
	logic signed [COEF_W-1:0]  row1_s2 [4];
	logic signed [PROD_W-1:0]  pa_s1 [NPAIR];
	logic signed [PROD_W-1:0]  pb_s1 [NPAIR];
	logic signed [MINOR_W-1:0] mn_s2 [NPAIR];
	logic signed [TERM_W-1:0]  t_s3 [12];
	det_t                      det_s4;

	function automatic logic signed [COEF_W-1:0] cf(input logic [NCOEF*COEF_W-1:0] v,
		input int r, input int c);
		return $signed(v[(4*r+c)*COEF_W +: COEF_W]);
	endfunction

	function automatic logic signed [TERM_W-1:0] mul(input logic signed [COEF_W-1:0] a,
		input logic signed [MINOR_W-1:0] m);
		return TERM_W'(a * m);
	endfunction

	// Stage 1: cross products of rows two and three.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 4; c++) begin
				row1_s1[c] <= cf(coef, 0, c);
			end
			for (int p = 0; p < NPAIR; p++) begin
				pa_s1[p] <= PROD_W'(cf(coef, 1, PAIR_I[p]) * cf(coef, 2, PAIR_J[p]));
				pb_s1[p] <= PROD_W'(cf(coef, 1, PAIR_J[p]) * cf(coef, 2, PAIR_I[p]));
			end
		end
	end

	// Stage 2: 2x2 minors.
	always_ff @(posedge clk) begin
		if (en) begin
			row1_s2 <= row1_s1;
			for (int p = 0; p < NPAIR; p++) begin
				mn_s2[p] <= MINOR_W'(pa_s1[p]) - MINOR_W'(pb_s1[p]);
			end
		end
	end

	// Stage 3: expand along row one.
	always_ff @(posedge clk) begin
		if (en) begin
			t_s3[0]  <= mul(row1_s2[COL_A], mn_s2[M_BC]);
			t_s3[1]  <= mul(row1_s2[COL_B], mn_s2[M_AC]);
			t_s3[2]  <= mul(row1_s2[COL_C], mn_s2[M_AB]);
			t_s3[3]  <= mul(row1_s2[COL_D], mn_s2[M_BC]);
			t_s3[4]  <= mul(row1_s2[COL_B], mn_s2[M_CD]);
			t_s3[5]  <= mul(row1_s2[COL_C], mn_s2[M_BD]);
			t_s3[6]  <= mul(row1_s2[COL_A], mn_s2[M_CD]);
			t_s3[7]  <= mul(row1_s2[COL_D], mn_s2[M_AC]);
			t_s3[8]  <= mul(row1_s2[COL_C], mn_s2[M_AD]);
			t_s3[9]  <= mul(row1_s2[COL_A], mn_s2[M_BD]);
			t_s3[10] <= mul(row1_s2[COL_B], mn_s2[M_AD]);
			t_s3[11] <= mul(row1_s2[COL_D], mn_s2[M_AB]);
		end
	end

	// Stage 4: sums; the numerators use column -d, folded into the signs.
	always_ff @(posedge clk) begin
		if (en) begin
			det_s4.den <= DET_W'(t_s3[0]) - DET_W'(t_s3[1]) + DET_W'(t_s3[2]);
			det_s4.nx  <= DET_W'(t_s3[5]) - DET_W'(t_s3[3]) - DET_W'(t_s3[4]);
			det_s4.ny  <= DET_W'(t_s3[6]) + DET_W'(t_s3[7]) - DET_W'(t_s3[8]);
			det_s4.nz  <= DET_W'(t_s3[10]) - DET_W'(t_s3[9]) - DET_W'(t_s3[11]);
		end
	end

	assign det = det_s4;

endmodule

// ===== hw/rtl/lsolve_div.sv =====
// Pipelined restoring divider: one quotient bit per step stage, signed Q16.16 result with saturation.
module lsolve_div
	import lsolve_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [DET_W-1:0]  num,
	input  logic [MAG_W-1:0]         den_mag,
	input  logic                     den_neg,
	output logic [SOL_W-1:0]         sol,
	output logic                     sat
);

	logic [MAG_W-1:0] rem_q [DIV_STEPS+1];
	logic [Q_W-1:0]   nb_q  [DIV_STEPS+1];
	logic [Q_W-1:0]   quo_q [DIV_STEPS+1];
	logic [MAG_W-1:0] den_q [DIV_STEPS+1];
	logic             neg_q [DIV_STEPS+1];
	logic             ovf_q [DIV_STEPS+1];
	logic [SOL_W-1:0] sol_q;
	logic             sat_q;

	logic [DET_W-1:0] num_abs;
	logic [MAG_W-1:0] num_mag;

	assign num_abs = num[DET_W-1] ? DET_W'(-num) : DET_W'(num);
	assign num_mag = num_abs[MAG_W-1:0];

	// Entry: magnitude, sign, overflow precheck and first partial remainder.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= MAG_W'(num_mag[MAG_W-1:FRAC_W+1]);
			nb_q[0]  <= {num_mag[FRAC_W:0], {FRAC_W{1'b0}}};
			quo_q[0] <= '0;
			den_q[0] <= den_mag;
			neg_q[0] <= num[DET_W-1] ^ den_neg;
			ovf_q[0] <= {{(FRAC_W+1){1'b0}}, num_mag} >= {den_mag, {(FRAC_W+1){1'b0}}};
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [MAG_W:0] trial;
		logic           ge;
		assign trial = {rem_q[k], nb_q[k][Q_W-1]};
		assign ge    = trial >= {1'b0, den_q[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= ge ? MAG_W'(trial - {1'b0, den_q[k]}) : trial[MAG_W-1:0];
				nb_q[k+1]  <= {nb_q[k][Q_W-2:0], 1'b0};
				quo_q[k+1] <= {quo_q[k][Q_W-2:0], ge};
				den_q[k+1] <= den_q[k];
				neg_q[k+1] <= neg_q[k];
				ovf_q[k+1] <= ovf_q[k];
			end
		end
	end

	// Exit: apply sign and clamp to the Q16.16 range.
	logic [Q_W-1:0] q;
	logic           neg;
	logic           over;
	assign q    = quo_q[DIV_STEPS];
	assign neg  = neg_q[DIV_STEPS];
	assign over = ovf_q[DIV_STEPS] ||
		(neg ? (q > Q_W'(SAT_NEG)) : (q > Q_W'(SAT_POS)));

	always_ff @(posedge clk) begin
		if (en) begin
			sat_q <= over;
			if (over) begin
				sol_q <= neg ? SAT_NEG : SAT_POS;
			end else begin
				sol_q <= neg ? SOL_W'(-q) : q[SOL_W-1:0];
			end
		end
	end

	assign sol = sol_q;
	assign sat = sat_q;

endmodule

// ===== hw/rtl/three_by_three_linear_solver.sv =====
// Three-plane crossing point solver (Cramer's rule), top level.
//
//  channel   dir  payload (low bit first)
//  s_*       in   tdata: a,b,c,d of plane 1, plane 2, plane 3, 16 bits each, Q8.8
//  m_*       out  tdata: sol_x, sol_y, sol_z, 32 bits each, Q16.16; tuser: status
//  cfg_*     in   wdata: singular_threshold, 48 bits, Q24.24
//
// One request enters per cycle while the pipeline advances; each passes through four
// determinant stages, one threshold stage and a 35-stage divider whose step stages
// each yield one quotient bit. The whole pipeline advances together whenever the
// output stage is empty or being taken, so a stall holds every stage in place.
// Reset clears the valid chain and the threshold; payload registers are not reset.
`include "three_by_three_linear_solver_defines.svh"
module three_by_three_linear_solver
	import lsolve_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [MAG_W-1:0]        cfg_wdata,   // singular_threshold
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [NCOEF*COEF_W-1:0] s_tdata,     // a_first..d_first, a_second..d_second,
	                                              // a_third..d_third
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [3*SOL_W-1:0]      m_tdata,     // sol_x, sol_y, sol_z
	output logic [1:0]              m_tuser      // status
);

	logic [MAG_W-1:0] thr_q;
	logic             vld_q [TOT_LAT];
	logic             sing_q [DIV_LAT+1];
	logic             adv;

	det_t             det;
	det_t             det_s5;
	logic [MAG_W-1:0] den_mag_s5;
	logic [DET_W-1:0] den_abs;

	logic [SOL_W-1:0] sol [3];
	logic             sat [3];

	// Advance everything while the output stage is free or drained this cycle.
	assign adv      = !vld_q[TOT_LAT-1] || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Valid bits ride alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOT_LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= s_tvalid;
			for (int i = 1; i < TOT_LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	lsolve_det u_det (
		.clk  (clk),
		.en   (adv),
		.coef (s_tdata),
		.det  (det)
	);

	assign den_abs = det.den[DET_W-1] ? DET_W'(-det.den) : DET_W'(det.den);

	// Threshold stage: flag singular systems, hold |D| for the dividers.
	always_ff @(posedge clk) begin
		if (adv) begin
			det_s5     <= det;
			den_mag_s5 <= den_abs[MAG_W-1:0];
			sing_q[0]  <= den_abs[MAG_W-1:0] <= thr_q;
			for (int i = 1; i <= DIV_LAT; i++) begin
				sing_q[i] <= sing_q[i-1];
			end
		end
	end

	lsolve_div u_div_x (
		.clk     (clk),
		.en      (adv),
		.num     (det_s5.nx),
		.den_mag (den_mag_s5),
		.den_neg (det_s5.den[DET_W-1]),
		.sol     (sol[0]),
		.sat     (sat[0])
	);

	lsolve_div u_div_y (
		.clk     (clk),
		.en      (adv),
		.num     (det_s5.ny),
		.den_mag (den_mag_s5),
		.den_neg (det_s5.den[DET_W-1]),
		.sol     (sol[1]),
		.sat     (sat[1])
	);

	lsolve_div u_div_z (
		.clk     (clk),
		.en      (adv),
		.num     (det_s5.nz),
		.den_mag (den_mag_s5),
		.den_neg (det_s5.den[DET_W-1]),
		.sol     (sol[2]),
		.sat     (sat[2])
	);

	// Drop quotients of singular systems; report zeros instead.
	logic sing_out;
	assign sing_out = sing_q[DIV_LAT];
	assign m_tvalid = vld_q[TOT_LAT-1];
	assign m_tdata  = sing_out ? '0 : {sol[2], sol[1], sol[0]};
	always_comb begin
		if (sing_out) begin
			m_tuser = ST_SINGULAR;
		end else if (sat[0] || sat[1] || sat[2]) begin
			m_tuser = ST_SATURATED;
		end else begin
			m_tuser = ST_SOLVED;
		end
	end

	// A saturated result carries at least one coordinate on a rail.
	logic sat_out;
	logic sat_rail;
	assign sat_out  = m_tvalid && m_tuser == ST_SATURATED;
	assign sat_rail = m_tdata[31:0] == SAT_POS || m_tdata[31:0] == SAT_NEG ||
		m_tdata[63:32] == SAT_POS || m_tdata[63:32] == SAT_NEG ||
		m_tdata[95:64] == SAT_POS || m_tdata[95:64] == SAT_NEG;

	`LSOLVE_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")
	`LSOLVE_ASSERT(a_sat_on_rail, sat_out |-> sat_rail, "saturated status without a clamped value")
	`LSOLVE_NEVER(a_no_code_three, m_tvalid && m_tuser == 2'b11, "undefined status code")

endmodule
